>>> rtl/core/matrix_inverse_3x3_assert.svh
// assertion macros for the matrix inverse rtl, included by the flow control
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

// clocked assertion, off while reset is held
`define MI3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also runs during reset
`define MI3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/mi3_pkg.sv
// types, stage map and divider step for the 3x3 matrix inverse
package mi3_pkg;

  localparam int unsigned IN_W   = 16;  // Q4.12 entry
  localparam int unsigned PROD_W = 32;  // Q8.24 product
  localparam int unsigned ADJ_W  = 33;  // cofactor
  localparam int unsigned TERM_W = 49;  // row entry times cofactor
  localparam int unsigned DET_W  = 50;  // determinant, |det| < 2^48
  localparam int unsigned DEN_W  = 48;  // divisor magnitude
  localparam int unsigned MAG_W  = 32;  // cofactor magnitude
  localparam int unsigned NUM_W  = 60;  // rounded dividend
  localparam int unsigned Q_W    = 32;  // quotient bits
  localparam int unsigned OUT_W  = 32;  // Q15.16 result
  localparam int unsigned FRAC_SHIFT = 28;
  localparam int unsigned NUM_ELEM   = 9;

  // divider: two quotient bits per stage
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DIV_STG   = Q_W / DIV_STEPS;

  // pipeline stage map
  localparam int unsigned ST_IN   = 0;
  localparam int unsigned ST_PROD = 1;
  localparam int unsigned ST_ADJ  = 2;
  localparam int unsigned ST_TERM = 3;
  localparam int unsigned ST_DET  = 4;
  localparam int unsigned ST_ABS  = 5;
  localparam int unsigned ST_NUM  = 6;
  localparam int unsigned ST_OVF  = 7;
  localparam int unsigned ST_DIV0 = 8;
  localparam int unsigned ST_OUT  = ST_DIV0 + DIV_STG;
  localparam int unsigned NSTG    = ST_OUT + 1;

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [IN_W-1:0]  elem_t;
  typedef logic signed [ADJ_W-1:0] adj_t;
  typedef logic signed [DET_W-1:0] det_t;

  // per-stage load enables from the flow control
  typedef struct packed {
    logic [NSTG-1:0] en;
  } pipe_ctl_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   lo;
  } div_state_t;

  // one restoring division step: next dividend bit in, one quotient bit out
  function automatic div_state_t div_step(div_state_t s, logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    div_state_t     r;
    logic           qb;
    t  = {s.rem, s.lo[Q_W-1]};
    qb = (t >= {1'b0, den});
    r.rem = qb ? DEN_W'(t - {1'b0, den}) : DEN_W'(t);
    r.lo  = {s.lo[Q_W-2:0], qb};
    return r;
  endfunction

endpackage

>>> rtl/core/mi3_ctrl.sv
// valid bits and stall chain of the inverse pipeline
module mi3_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mi3_pkg::pipe_ctl_t ctl_o
);
  import mi3_pkg::*;

  logic [NSTG-1:0] valid_q, valid_d;
  logic [NSTG:0]   ready;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ready[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      if (ready[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k-1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctl_o.en    = ready[NSTG-1:0];
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NSTG-1];

  `include "matrix_inverse_3x3_assert.svh"

  // input only backs up when every stage holds a beat
  `MI3_ASSERT(a_full_on_stall, !in_ready_o |-> (&valid_q), "input stalled with a bubble")
  // beats are neither lost nor invented
  `MI3_ASSERT(a_conserve, $countones(valid_q) == $past($countones(valid_q)) + int'($past(in_valid_i && in_ready_o)) - int'($past(out_valid_o && out_ready_i)), "beat count mismatch")
  // an accepted beat lands in the first stage
  `MI3_ASSERT(a_enter, (in_valid_i && in_ready_o) |=> valid_q[0], "accepted beat dropped")
  // reset empties the pipeline
  `MI3_ASSERT_ALWAYS(a_reset, !rst_ni |=> !out_valid_o, "output valid during reset")
endmodule

>>> rtl/core/mi3_cofactor.sv
// products, adjugate cofactors and determinant stages
module mi3_cofactor (
  input  logic               clk_i,
  input  mi3_pkg::pipe_ctl_t ctl_i,
  input  mi3_pkg::elem_t     m_i   [mi3_pkg::NUM_ELEM],
  output mi3_pkg::adj_t      adj_o [mi3_pkg::NUM_ELEM],
  output mi3_pkg::det_t      det_o
);
  import mi3_pkg::*;

  // index pairs of the adjugate: adj = m[a]*m[b] - m[c]*m[d]
  localparam int unsigned PA [NUM_ELEM] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int unsigned PB [NUM_ELEM] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int unsigned PC [NUM_ELEM] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int unsigned PD [NUM_ELEM] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  elem_t                     m_q    [NUM_ELEM];
  logic signed [PROD_W-1:0]  pl_q   [NUM_ELEM];
  logic signed [PROD_W-1:0]  pr_q   [NUM_ELEM];
  elem_t                     r0p_q  [3];
  elem_t                     r0a_q  [3];
  adj_t                      adj2_q [NUM_ELEM];
  adj_t                      adj3_q [NUM_ELEM];
  adj_t                      adj4_q [NUM_ELEM];
  logic signed [TERM_W-1:0]  term_q [3];
  det_t                      det_q;

  // input register
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_IN]) begin
      m_q <= m_i;
    end
  end

  // the eighteen products
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_PROD]) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        pl_q[i] <= PROD_W'(m_q[PA[i]]) * PROD_W'(m_q[PB[i]]);
        pr_q[i] <= PROD_W'(m_q[PC[i]]) * PROD_W'(m_q[PD[i]]);
      end
      for (int j = 0; j < 3; j++) begin
        r0p_q[j] <= m_q[j];
      end
    end
  end

  // cofactor differences
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_ADJ]) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        adj2_q[i] <= ADJ_W'(pl_q[i]) - ADJ_W'(pr_q[i]);
      end
      r0a_q <= r0p_q;
    end
  end

  // first row times first column of the adjugate
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_TERM]) begin
      term_q[0] <= TERM_W'(r0a_q[0]) * TERM_W'(adj2_q[0]);
      term_q[1] <= TERM_W'(r0a_q[1]) * TERM_W'(adj2_q[3]);
      term_q[2] <= TERM_W'(r0a_q[2]) * TERM_W'(adj2_q[6]);
      adj3_q    <= adj2_q;
    end
  end

  // determinant sum
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_DET]) begin
      det_q  <= DET_W'(term_q[0]) + DET_W'(term_q[1]) + DET_W'(term_q[2]);
      adj4_q <= adj3_q;
    end
  end

  assign adj_o = adj4_q;
  assign det_o = det_q;
endmodule

>>> rtl/core/mi3_div_lane.sv
// one entry: rounded divide by the determinant, then saturate
module mi3_div_lane (
  input  logic                      clk_i,
  input  mi3_pkg::pipe_ctl_t        ctl_i,
  input  mi3_pkg::adj_t             cof_i,
  input  mi3_pkg::det_t             det_i,
  output logic [mi3_pkg::OUT_W-1:0] b_o,
  output logic                      zero_o
);
  import mi3_pkg::*;

  logic [DEN_W-1:0] den_q  [DIV_STG+3];
  logic             neg_q  [DIV_STG+3];
  logic             zero_q [DIV_STG+3];
  logic [MAG_W-1:0] mag_q;
  logic [NUM_W-1:0] num_q;
  logic             ovf_q  [DIV_STG+1];
  div_state_t       ds_q   [DIV_STG+1];
  logic [OUT_W-1:0] b_q;
  logic             zero_out_q;

  // magnitudes, result sign and zero determinant flag
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_ABS]) begin
      den_q[0]  <= det_i[DET_W-1] ? DEN_W'(-det_i) : DEN_W'(det_i);
      mag_q     <= cof_i[ADJ_W-1] ? MAG_W'(-cof_i) : MAG_W'(cof_i);
      neg_q[0]  <= cof_i[ADJ_W-1] ^ det_i[DET_W-1];
      zero_q[0] <= (det_i == '0);
    end
  end

  // scaled dividend plus half the divisor for rounding
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_NUM]) begin
      num_q     <= (NUM_W'(mag_q) << FRAC_SHIFT) + NUM_W'(den_q[0] >> 1);
      den_q[1]  <= den_q[0];
      neg_q[1]  <= neg_q[0];
      zero_q[1] <= zero_q[0];
    end
  end

  // quotient overflow check and divider seed
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_OVF]) begin
      ovf_q[0]     <= (DEN_W'(num_q[NUM_W-1:Q_W]) >= den_q[1]);
      ds_q[0].rem  <= DEN_W'(num_q[NUM_W-1:Q_W]);
      ds_q[0].lo   <= num_q[Q_W-1:0];
      den_q[2]     <= den_q[1];
      neg_q[2]     <= neg_q[1];
      zero_q[2]    <= zero_q[1];
    end
  end

  // restoring divider, two bits per stage
  for (genvar g = 0; g < DIV_STG; g++) begin : g_div
    div_state_t st;
    always_comb begin
      st = ds_q[g];
      for (int s = 0; s < DIV_STEPS; s++) begin
        st = div_step(st, den_q[g+2]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (ctl_i.en[ST_DIV0+g]) begin
        ds_q[g+1]   <= st;
        ovf_q[g+1]  <= ovf_q[g];
        den_q[g+3]  <= den_q[g+2];
        neg_q[g+3]  <= neg_q[g+2];
        zero_q[g+3] <= zero_q[g+2];
      end
    end
  end

  // sign and saturation into the output register
  logic [Q_W-1:0] q;
  logic [OUT_W-1:0] b_d;
  always_comb begin
    q = ds_q[DIV_STG].lo;
    if (zero_q[DIV_STG+2]) begin
      b_d = '0;
    end else if (neg_q[DIV_STG+2]) begin
      b_d = (ovf_q[DIV_STG] || q[Q_W-1]) ? SAT_NEG : OUT_W'(-q);
    end else begin
      b_d = (ovf_q[DIV_STG] || q[Q_W-1]) ? SAT_POS : OUT_W'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[ST_OUT]) begin
      b_q        <= b_d;
      zero_out_q <= zero_q[DIV_STG+2];
    end
  end

  assign b_o    = b_q;
  assign zero_o = zero_out_q;
endmodule

>>> rtl/core/matrix_inverse_3x3.sv
// 3x3 matrix inverse by adjugate: takes one Q4.12 matrix per beat and returns
// its Q15.16 inverse, rounded to nearest and saturated, with a singular flag
// (entries zero) when the determinant is exactly zero. The block accepts one
// matrix every cycle unless an output stall has filled every stage; each
// matrix passes through five cofactor and determinant stages, three divider
// setup stages, sixteen divider stages that retire two quotient bits each, and
// the output register. A stall at the output backs up stage by stage, so empty
// stages keep filling while a result waits.
module matrix_inverse_3x3 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,   // a00 a01 a02 a10 a11 a12 a20 a21 a22, 16 bits each
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,   // b00 b01 b02 b10 b11 b12 b20 b21 b22, 32 bits each
  output logic         m_tuser    // singular
);
  import mi3_pkg::*;

  pipe_ctl_t        ctl;
  elem_t            m_in [NUM_ELEM];
  adj_t             adj  [NUM_ELEM];
  det_t             det;
  logic [OUT_W-1:0] b    [NUM_ELEM];
  logic [NUM_ELEM-1:0] zero;

  // flow control
  mi3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .ctl_o       (ctl)
  );

  // unpack the input beat
  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      m_in[i] = s_tdata[i*IN_W +: IN_W];
    end
  end

  mi3_cofactor u_cof (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .m_i   (m_in),
    .adj_o (adj),
    .det_o (det)
  );

  // one divider lane per entry
  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
    mi3_div_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .cof_i  (adj[i]),
      .det_i  (det),
      .b_o    (b[i]),
      .zero_o (zero[i])
    );
    assign m_tdata[i*OUT_W +: OUT_W] = b[i];
  end

  // every lane sees the same determinant
  assign m_tuser = &zero;
endmodule
